// ----- rtl/prm_pkg.sv -----
// ----------------------------------------------------------------------------
// Polygon region measure package
// Shared widths, saturation limits, payload types and helper functions.
// ----------------------------------------------------------------------------
package prm_pkg;

    localparam int COORD_BITS = 16;
    localparam int TERM_BITS  = 2 * COORD_BITS + 1;
    localparam int CROSS_BITS = 44;
    localparam int AREA_BITS  = 34;
    localparam int HELD_BITS  = AREA_BITS - 1;
    localparam int HOLE_BITS  = CROSS_BITS - 1;
    localparam int HALF_BITS  = CROSS_BITS - 1;
    localparam int PERIM_BITS = 26;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [TERM_BITS-1:0]  t_term;
    typedef logic signed [CROSS_BITS-1:0] t_cross;
    typedef logic signed [AREA_BITS-1:0]  t_area;
    typedef logic [PERIM_BITS-1:0]        t_perim;
    typedef logic [HELD_BITS-1:0]         t_held;
    typedef logic [HOLE_BITS-1:0]         t_hole;
    typedef logic [HALF_BITS-1:0]         t_half;

    typedef struct packed {
        t_coord min_x;
        t_coord min_y;
        t_coord max_x;
        t_coord max_y;
    } t_box;

    localparam t_cross CROSS_MAX   = {1'b0, {(CROSS_BITS-1){1'b1}}};
    localparam t_cross CROSS_MIN   = {1'b1, {(CROSS_BITS-1){1'b0}}};
    localparam t_held  OUTLINE_MAX = {HELD_BITS{1'b1}};
    localparam t_hole  HOLE_MAX    = {HOLE_BITS{1'b1}};
    localparam t_area  AREA_MAX    = {1'b0, {(AREA_BITS-1){1'b1}}};
    localparam t_area  AREA_MIN    = {1'b1, {(AREA_BITS-1){1'b0}}};
    localparam t_perim PERIM_MAX   = {PERIM_BITS{1'b1}};

    // Adds one cross term to the contour sum, clamping at the signed range.
    function automatic t_cross sat_cross_add(input t_cross acc, input t_term term);
        logic signed [CROSS_BITS:0] s;
        t_cross res;
        s = (CROSS_BITS+1)'(acc) + (CROSS_BITS+1)'(term);
        if (s[CROSS_BITS] != s[CROSS_BITS-1]) begin
            res = s[CROSS_BITS] ? CROSS_MIN : CROSS_MAX;
        end else begin
            res = s[CROSS_BITS-1:0];
        end
        return res;
    endfunction

    // Length of an edge if it is axis-aligned, zero otherwise.
    function automatic logic [COORD_BITS-1:0] edge_len(input t_coord ax, input t_coord ay,
                                                      input t_coord bx, input t_coord by);
        logic signed [COORD_BITS:0] dx;
        logic signed [COORD_BITS:0] dy;
        logic [COORD_BITS:0] mx;
        logic [COORD_BITS:0] my;
        logic [COORD_BITS-1:0] len;
        dx = (COORD_BITS+1)'(ax) - (COORD_BITS+1)'(bx);
        dy = (COORD_BITS+1)'(ay) - (COORD_BITS+1)'(by);
        mx = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
        my = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
        len = '0;
        // A degenerate edge has both deltas zero, so both arms add nothing.
        if (ay == by) begin
            len = len + mx[COORD_BITS-1:0];
        end
        if (ax == bx) begin
            len = len + my[COORD_BITS-1:0];
        end
        return len;
    endfunction

endpackage

// ----- rtl/prm_if.sv -----
// ----------------------------------------------------------------------------
// Polygon region measure channels
// Valid/ready interfaces for the vertex input and the region result output.
// ----------------------------------------------------------------------------
interface prm_vertex_if;
    logic            valid;
    logic            ready;
    prm_pkg::t_coord vertex_x;
    prm_pkg::t_coord vertex_y;
    logic            contour_end;
    logic            region_end;

    modport source (output valid, vertex_x, vertex_y, contour_end, region_end,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, contour_end, region_end,
                    output ready);
endinterface

interface prm_result_if;
    logic            valid;
    logic            ready;
    prm_pkg::t_area  area;
    prm_pkg::t_perim outline_perimeter;
    prm_pkg::t_coord box_min_x;
    prm_pkg::t_coord box_min_y;
    prm_pkg::t_coord box_max_x;
    prm_pkg::t_coord box_max_y;

    modport source (output valid, area, outline_perimeter, box_min_x, box_min_y,
                    box_max_x, box_max_y, input ready);
    modport sink   (input valid, area, outline_perimeter, box_min_x, box_min_y,
                    box_max_x, box_max_y, output ready);
endinterface

// ----- rtl/polygon_region_measure_core.sv -----
// ----------------------------------------------------------------------------
// Polygon region measure core
// Area with holes, rectilinear outline perimeter and outline bounding box.
// ----------------------------------------------------------------------------
// Vertices enter on i_vertex, one item per vertex, flagged with contour_end and
// region_end. The first contour of a region is its outline; later ones are
// holes. One item leaves on o_result for each vertex that ends a region.
// Throughput is one vertex per cycle. A region-ending vertex passes through
// these registers in order: input register, cross products and
// perimeter, contour sum, halved magnitude, area totals, output register.
// Each stage holds one item and moves on whenever the stage after it is
// free, so vertices keep flowing while a result waits at the output. When
// the receiver stalls long enough, the stages fill up and i_vertex.ready
// drops. The per-cycle feedback paths are the saturating contour sum (two
// chained 44-bit adds) and the saturating hole total.
// Synchronous reset empties every stage, dropping any result still in
// flight, and starts a fresh region whose next contour is its outline.
// ----------------------------------------------------------------------------
module polygon_region_measure_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    prm_vertex_if.sink          i_vertex,
    prm_result_if.source        o_result
);

    // Stage valids and handshake.
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_out_vld;
    logic out_free, e_free, d_free, c_free, b_free, a_free;
    logic adv_a, adv_b, adv_c, adv_d, adv_e;
    logic in_fire;

    // Stage A: accepted vertex.
    prm_pkg::t_coord r_a_x, r_a_y;
    logic            r_a_cend, r_a_rend;

    // Contour and region state.
    prm_pkg::t_coord r_start_x, r_start_y, r_prev_x, r_prev_y;
    logic            r_at_start, r_in_outline;
    prm_pkg::t_box   r_box;
    prm_pkg::t_perim r_perim;
    prm_pkg::t_cross r_sum;
    prm_pkg::t_held  r_held;
    prm_pkg::t_hole  r_hole;

    // Stage B: cross terms.
    prm_pkg::t_term  r_b_t1, r_b_t2;
    logic            r_b_first, r_b_cend, r_b_rend, r_b_outline;
    prm_pkg::t_box   r_b_box;
    prm_pkg::t_perim r_b_perim;

    // Stage C: contour sum lives in r_sum.
    logic            r_c_cend, r_c_rend, r_c_outline;
    prm_pkg::t_box   r_c_box;
    prm_pkg::t_perim r_c_perim;

    // Stage D: halved contour area.
    prm_pkg::t_half  r_d_half;
    logic            r_d_rend, r_d_outline;
    prm_pkg::t_box   r_d_box;
    prm_pkg::t_perim r_d_perim;

    // Stage E: region totals.
    prm_pkg::t_held  r_e_held;
    prm_pkg::t_hole  r_e_hole;
    prm_pkg::t_box   r_e_box;
    prm_pkg::t_perim r_e_perim;

    // Output register.
    prm_pkg::t_area  r_out_area;
    prm_pkg::t_box   r_out_box;
    prm_pkg::t_perim r_out_perim;

    // ------------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------------
    assign out_free = !r_out_vld || o_result.ready;
    assign adv_e    = r_e_vld && out_free;
    assign e_free   = !r_e_vld || adv_e;
    // Only region-ending items travel on past stage D, and only contour-ending
    // items past stage C; the others retire after updating the state.
    assign adv_d    = r_d_vld && (!r_d_rend || e_free);
    assign d_free   = !r_d_vld || adv_d;
    assign adv_c    = r_c_vld && (!r_c_cend || d_free);
    assign c_free   = !r_c_vld || adv_c;
    assign adv_b    = r_b_vld && c_free;
    assign b_free   = !r_b_vld || adv_b;
    assign adv_a    = r_a_vld && b_free;
    assign a_free   = !r_a_vld || adv_a;

    assign i_vertex.ready = a_free;
    assign in_fire        = i_vertex.valid && a_free;

    // ------------------------------------------------------------------------
    // Stage A to B: cross products, perimeter, bounding box
    // ------------------------------------------------------------------------
    logic                                first, outl, cend;
    prm_pkg::t_coord                     sx, sy;
    logic signed [2*prm_pkg::COORD_BITS-1:0] p_prev0, p_prev1, p_cl0, p_cl1;
    prm_pkg::t_term                      n_t1, n_t2;
    logic [prm_pkg::COORD_BITS-1:0]      d1, d2;
    logic [prm_pkg::PERIM_BITS:0]        perim_sum;
    prm_pkg::t_perim                     n_perim;
    prm_pkg::t_box                       n_box;

    assign first = r_at_start;
    assign outl  = r_in_outline;
    assign cend  = r_a_cend || r_a_rend;
    // The first vertex of a contour is its own start point.
    assign sx    = first ? r_a_x : r_start_x;
    assign sy    = first ? r_a_y : r_start_y;

    assign p_prev0 = r_prev_x * r_a_y;
    assign p_prev1 = r_prev_y * r_a_x;
    assign p_cl0   = r_a_x * sy;
    assign p_cl1   = r_a_y * sx;

    assign n_t1 = first ? '0 :
                  prm_pkg::TERM_BITS'(p_prev0) - prm_pkg::TERM_BITS'(p_prev1);
    assign n_t2 = cend ? prm_pkg::TERM_BITS'(p_cl0) - prm_pkg::TERM_BITS'(p_cl1) : '0;

    assign d1 = (!first && outl) ? prm_pkg::edge_len(r_prev_x, r_prev_y, r_a_x, r_a_y) : '0;
    assign d2 = (cend && outl) ? prm_pkg::edge_len(r_a_x, r_a_y, sx, sy) : '0;

    // Both lengths are non-negative, so one clamp after the sum is exact.
    assign perim_sum = {1'b0, r_perim} + (prm_pkg::PERIM_BITS+1)'(d1)
                     + (prm_pkg::PERIM_BITS+1)'(d2);
    assign n_perim   = (perim_sum > (prm_pkg::PERIM_BITS+1)'(prm_pkg::PERIM_MAX)) ?
                       prm_pkg::PERIM_MAX : perim_sum[prm_pkg::PERIM_BITS-1:0];

    always_comb begin
        n_box = r_box;
        if (outl) begin
            if (first) begin
                n_box.min_x = r_a_x;
                n_box.max_x = r_a_x;
                n_box.min_y = r_a_y;
                n_box.max_y = r_a_y;
            end else begin
                if (r_a_x < r_box.min_x) n_box.min_x = r_a_x;
                if (r_a_x > r_box.max_x) n_box.max_x = r_a_x;
                if (r_a_y < r_box.min_y) n_box.min_y = r_a_y;
                if (r_a_y > r_box.max_y) n_box.max_y = r_a_y;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage B to C: saturating contour sum
    // ------------------------------------------------------------------------
    prm_pkg::t_cross sum_base, sum_mid, n_sum;

    assign sum_base = r_b_first ? '0 : r_sum;
    assign sum_mid  = prm_pkg::sat_cross_add(sum_base, r_b_t1);
    assign n_sum    = prm_pkg::sat_cross_add(sum_mid, r_b_t2);

    // ------------------------------------------------------------------------
    // Stage C to D: half of the absolute contour sum
    // ------------------------------------------------------------------------
    logic [prm_pkg::CROSS_BITS-1:0] sum_mag;

    assign sum_mag = r_sum[prm_pkg::CROSS_BITS-1] ?
                     prm_pkg::CROSS_BITS'(-r_sum) : prm_pkg::CROSS_BITS'(r_sum);

    // ------------------------------------------------------------------------
    // Stage D to E: outline area and hole total
    // ------------------------------------------------------------------------
    logic [prm_pkg::HOLE_BITS:0] hole_sum;
    prm_pkg::t_held              n_held;
    prm_pkg::t_hole              n_hole;

    assign hole_sum = {1'b0, r_hole} + {1'b0, r_d_half};

    always_comb begin
        n_held = r_held;
        n_hole = r_hole;
        if (r_d_outline) begin
            n_held = (r_d_half > prm_pkg::HALF_BITS'(prm_pkg::OUTLINE_MAX)) ?
                     prm_pkg::OUTLINE_MAX : r_d_half[prm_pkg::HELD_BITS-1:0];
        end else begin
            n_hole = (hole_sum > (prm_pkg::HOLE_BITS+1)'(prm_pkg::HOLE_MAX)) ?
                     prm_pkg::HOLE_MAX : hole_sum[prm_pkg::HOLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Stage E to output: saturated net area
    // ------------------------------------------------------------------------
    logic signed [prm_pkg::HOLE_BITS:0] net;
    logic                               net_fits;
    prm_pkg::t_area                     n_area;

    assign net      = (prm_pkg::HOLE_BITS+1)'(r_e_held) - (prm_pkg::HOLE_BITS+1)'(r_e_hole);
    assign net_fits = (&net[prm_pkg::HOLE_BITS:prm_pkg::AREA_BITS-1])
                   || !(|net[prm_pkg::HOLE_BITS:prm_pkg::AREA_BITS-1]);
    assign n_area   = net_fits ? net[prm_pkg::AREA_BITS-1:0] :
                      (net[prm_pkg::HOLE_BITS] ? prm_pkg::AREA_MIN : prm_pkg::AREA_MAX);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld      <= 1'b0;
            r_b_vld      <= 1'b0;
            r_c_vld      <= 1'b0;
            r_d_vld      <= 1'b0;
            r_e_vld      <= 1'b0;
            r_out_vld    <= 1'b0;
            r_at_start   <= 1'b1;
            r_in_outline <= 1'b1;
            r_perim      <= '0;
            r_hole       <= '0;
            r_held       <= '0;
        end else begin
            if (a_free)   r_a_vld   <= i_vertex.valid;
            if (b_free)   r_b_vld   <= adv_a;
            if (c_free)   r_c_vld   <= adv_b;
            if (d_free)   r_d_vld   <= adv_c && r_c_cend;
            if (e_free)   r_e_vld   <= adv_d && r_d_rend;
            if (out_free) r_out_vld <= adv_e;

            if (adv_a) begin
                // A region end returns the geometry state to its reset values.
                r_perim      <= r_a_rend ? '0 : n_perim;
                r_at_start   <= cend;
                r_in_outline <= r_a_rend ? 1'b1 : (cend ? 1'b0 : r_in_outline);
            end
            if (adv_d) begin
                r_held <= r_d_rend ? '0 : n_held;
                r_hole <= r_d_rend ? '0 : n_hole;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_x    <= i_vertex.vertex_x;
            r_a_y    <= i_vertex.vertex_y;
            r_a_cend <= i_vertex.contour_end;
            r_a_rend <= i_vertex.region_end;
        end
        if (adv_a) begin
            r_prev_x <= r_a_x;
            r_prev_y <= r_a_y;
            if (first) begin
                r_start_x <= r_a_x;
                r_start_y <= r_a_y;
            end
            r_box       <= n_box;
            r_b_t1      <= n_t1;
            r_b_t2      <= n_t2;
            r_b_first   <= first;
            r_b_cend    <= cend;
            r_b_rend    <= r_a_rend;
            r_b_outline <= outl;
            r_b_box     <= n_box;
            r_b_perim   <= n_perim;
        end
        if (adv_b) begin
            r_sum       <= n_sum;
            r_c_cend    <= r_b_cend;
            r_c_rend    <= r_b_rend;
            r_c_outline <= r_b_outline;
            r_c_box     <= r_b_box;
            r_c_perim   <= r_b_perim;
        end
        if (adv_c && r_c_cend) begin
            r_d_half    <= sum_mag[prm_pkg::CROSS_BITS-1:1];
            r_d_rend    <= r_c_rend;
            r_d_outline <= r_c_outline;
            r_d_box     <= r_c_box;
            r_d_perim   <= r_c_perim;
        end
        if (adv_d && r_d_rend) begin
            r_e_held  <= n_held;
            r_e_hole  <= n_hole;
            r_e_box   <= r_d_box;
            r_e_perim <= r_d_perim;
        end
        if (adv_e) begin
            r_out_area  <= n_area;
            r_out_box   <= r_e_box;
            r_out_perim <= r_e_perim;
        end
    end

    assign o_result.valid             = r_out_vld;
    assign o_result.area              = r_out_area;
    assign o_result.outline_perimeter = r_out_perim;
    assign o_result.box_min_x         = r_out_box.min_x;
    assign o_result.box_min_y         = r_out_box.min_y;
    assign o_result.box_max_x         = r_out_box.max_x;
    assign o_result.box_max_y         = r_out_box.max_y;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_box.min_x <= r_out_box.max_x)
                   && (r_out_box.min_y <= r_out_box.max_y))
        else $error("result bounding box is inverted");

    a_region_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv_a && r_a_rend) |=> (r_perim == '0) && r_at_start && r_in_outline)
        else $error("geometry state not cleared after region end");

    a_hole_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv_d && r_d_rend) |=> (r_hole == '0))
        else $error("hole total not cleared after region end");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_result.ready) |=> r_out_vld && $stable(r_out_area)
                                        && $stable(r_out_perim) && $stable(r_out_box))
        else $error("result item changed while waiting for the receiver");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polygon region measure testbench
// Streams vertex items that form polygon regions with holes into the core.
// A model in this file works out area, rectilinear outline perimeter and
// outline box per region and checks every result item against it, with
// random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int          CYCLE_LIMIT  = 50000;
    localparam int          STALL_CYCLES = 400;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          PRINT_CAP    = 50;
    localparam int          SAT_LAPS     = 260;
    localparam int          HOLE_LAPS    = 3;
    localparam longint      CROSS_HI     = longint'(prm_pkg::CROSS_MAX);
    localparam longint      CROSS_LO     = longint'(prm_pkg::CROSS_MIN);
    localparam longint      OUTLINE_HI   = longint'(prm_pkg::OUTLINE_MAX);
    localparam longint      HOLES_HI     = longint'(prm_pkg::HOLE_MAX);
    localparam longint      AREA_HI      = longint'(prm_pkg::AREA_MAX);
    localparam longint      AREA_LO      = longint'(prm_pkg::AREA_MIN);
    localparam longint      PERIM_HI     = longint'(prm_pkg::PERIM_MAX);

    typedef enum int {COORD_FULL, COORD_NEAR, COORD_EXTREME} t_coord_mode;

    typedef struct packed {
        prm_pkg::t_area  area;
        prm_pkg::t_perim perimeter;
        prm_pkg::t_coord min_x;
        prm_pkg::t_coord min_y;
        prm_pkg::t_coord max_x;
        prm_pkg::t_coord max_y;
    } t_region_meas;

    logic i_clk;
    logic i_rst_n;

    prm_vertex_if vertex_ch ();
    prm_result_if result_ch ();

    polygon_region_measure_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vertex (vertex_ch),
        .o_result (result_ch)
    );

    // Region measurement state as seen from the accepted vertex stream.
    prm_pkg::t_coord first_x, first_y, last_x, last_y;
    prm_pkg::t_coord lo_x, lo_y, hi_x, hi_y;
    longint          cross_sum, outline_area, holes_area, perim_sum;
    bit              on_outline, contour_fresh;
    t_region_meas    region_expect_q[$];
    t_region_meas    oldest;

    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    int unsigned  items_sent;
    int unsigned  results_checked;
    int unsigned  mismatch_count;
    int unsigned  cycle_count;
    logic         stall_active;
    event         stall_kick;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint magnitude(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void clear_region();
        first_x       = '0;
        first_y       = '0;
        last_x        = '0;
        last_y        = '0;
        lo_x          = '0;
        lo_y          = '0;
        hi_x          = '0;
        hi_y          = '0;
        cross_sum     = 0;
        outline_area  = 0;
        holes_area    = 0;
        perim_sum     = 0;
        on_outline    = 1'b1;
        contour_fresh = 1'b1;
    endfunction

    function automatic void accumulate_cross(input prm_pkg::t_coord ax,
                                             input prm_pkg::t_coord ay,
                                             input prm_pkg::t_coord bx,
                                             input prm_pkg::t_coord by);
        longint term;
        term = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
        cross_sum = clamp_to(cross_sum + term, CROSS_LO, CROSS_HI);
    endfunction

    // Only axis-aligned edges count toward the outline perimeter.
    function automatic void accumulate_edge(input prm_pkg::t_coord ax,
                                            input prm_pkg::t_coord ay,
                                            input prm_pkg::t_coord bx,
                                            input prm_pkg::t_coord by);
        longint d;
        d = 0;
        if (ax == bx) d += magnitude(longint'(ay) - longint'(by));
        if (ay == by) d += magnitude(longint'(ax) - longint'(bx));
        perim_sum = clamp_to(perim_sum + d, 0, PERIM_HI);
    endfunction

    function automatic void absorb_vertex(input prm_pkg::t_coord x, input prm_pkg::t_coord y,
                                          input logic ce, input logic re);
        longint       half;
        t_region_meas meas;
        if (contour_fresh) begin
            first_x   = x;
            first_y   = y;
            cross_sum = 0;
            if (on_outline) begin
                lo_x = x;
                hi_x = x;
                lo_y = y;
                hi_y = y;
            end
            contour_fresh = 1'b0;
        end else begin
            accumulate_cross(last_x, last_y, x, y);
            if (on_outline) begin
                accumulate_edge(last_x, last_y, x, y);
                if (x < lo_x) lo_x = x;
                if (x > hi_x) hi_x = x;
                if (y < lo_y) lo_y = y;
                if (y > hi_y) hi_y = y;
            end
        end
        last_x = x;
        last_y = y;

        // A region end also closes the contour, flagged or not.
        if (ce || re) begin
            accumulate_cross(x, y, first_x, first_y);
            if (on_outline) accumulate_edge(x, y, first_x, first_y);
            half = magnitude(cross_sum) / 2;
            if (on_outline) begin
                outline_area = clamp_to(half, 0, OUTLINE_HI);
            end else begin
                holes_area = clamp_to(holes_area + half, 0, HOLES_HI);
            end
            on_outline    = 1'b0;
            contour_fresh = 1'b1;
        end

        if (re) begin
            meas.area      = prm_pkg::t_area'(clamp_to(outline_area - holes_area,
                                                       AREA_LO, AREA_HI));
            meas.perimeter = prm_pkg::t_perim'(perim_sum);
            meas.min_x     = lo_x;
            meas.min_y     = lo_y;
            meas.max_x     = hi_x;
            meas.max_y     = hi_y;
            region_expect_q.insert(region_expect_q.size(), meas);
            clear_region();
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string label, input longint got, input longint want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, label, got, want));
        end
    endtask

    // Input side: every accepted vertex item feeds the model.
    always @(posedge i_clk) begin
        if (i_rst_n && vertex_ch.valid && vertex_ch.ready) begin
            absorb_vertex(vertex_ch.vertex_x, vertex_ch.vertex_y,
                          vertex_ch.contour_end, vertex_ch.region_end);
        end
    end

    // Output side: every accepted result item is checked against the oldest
    // expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (region_expect_q.size() == 0) begin
                report_mismatch("result item with no region pending");
            end else begin
                oldest = region_expect_q.pop_front();
                compare_field("area", longint'(prm_pkg::t_area'(result_ch.area)),
                              longint'(prm_pkg::t_area'(oldest.area)));
                compare_field("perimeter", longint'(result_ch.outline_perimeter),
                              longint'(oldest.perimeter));
                compare_field("min_x", longint'(prm_pkg::t_coord'(result_ch.box_min_x)),
                              longint'(prm_pkg::t_coord'(oldest.min_x)));
                compare_field("min_y", longint'(prm_pkg::t_coord'(result_ch.box_min_y)),
                              longint'(prm_pkg::t_coord'(oldest.min_y)));
                compare_field("max_x", longint'(prm_pkg::t_coord'(result_ch.box_max_x)),
                              longint'(prm_pkg::t_coord'(oldest.max_x)));
                compare_field("max_y", longint'(prm_pkg::t_coord'(result_ch.box_max_y)),
                              longint'(prm_pkg::t_coord'(oldest.max_y)));
            end
            results_checked++;
        end
    end

    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            result_ch.ready <= !stall_active && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps running.
    initial begin
        stall_active = 1'b0;
        forever begin
            @(stall_kick);
            stall_active <= 1'b1;
            repeat (STALL_CYCLES) @(posedge i_clk);
            stall_active <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_vertex(input prm_pkg::t_coord x, input prm_pkg::t_coord y,
                               input logic ce, input logic re);
        while ($urandom_range(99) < send_idle_pct) begin
            vertex_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        vertex_ch.valid       <= 1'b1;
        vertex_ch.vertex_x    <= x;
        vertex_ch.vertex_y    <= y;
        vertex_ch.contour_end <= ce;
        vertex_ch.region_end  <= re;
        @(posedge i_clk);
        while (!vertex_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic prm_pkg::t_coord pick_coord(input t_coord_mode mode);
        prm_pkg::t_coord v;
        case (mode)
            COORD_FULL: v = prm_pkg::t_coord'($urandom);
            COORD_NEAR: v = prm_pkg::t_coord'(int'($urandom_range(64)) - 32);
            default: begin
                case ($urandom_range(5))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = 16'sh0000;
                    3:       v = 16'shFFFF;
                    4:       v = 16'sh8001;
                    default: v = 16'sh7FFE;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_contour(input int n, input bit closes_region,
                                input t_coord_mode mode, input bit recti);
        prm_pkg::t_coord x0, y0, x, y;
        bit              last;
        for (int i = 0; i < n; i++) begin
            last = (i == n - 1);
            if (i == 0) begin
                x  = pick_coord(mode);
                y  = pick_coord(mode);
                x0 = x;
                y0 = y;
            end else if (!recti) begin
                x = pick_coord(mode);
                y = pick_coord(mode);
            end else if ($urandom_range(7) != 0) begin
                // Alternate horizontal and vertical edges; the last vertex lines
                // up with the first so that the closing edge is aligned too.
                if (i % 2 == 1) begin
                    x = last ? x0 : pick_coord(mode);
                end else begin
                    y = last ? y0 : pick_coord(mode);
                end
            end
            send_vertex(x, y, last && (!closes_region || $urandom_range(1) == 1),
                        last && closes_region);
        end
    endtask

    task automatic send_region();
        t_coord_mode mode;
        bit          recti;
        int          holes;
        mode  = t_coord_mode'($urandom_range(2));
        recti = 1'($urandom_range(1));
        holes = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 3);
        send_contour($urandom_range(1, 9), holes == 0, mode, recti);
        for (int h = 0; h < holes; h++) begin
            send_contour($urandom_range(1, 6), h == holes - 1, mode, recti);
        end
    endtask

    // Vertices with random flags, so contours and regions break anywhere.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            send_vertex(pick_coord(t_coord_mode'($urandom_range(2))),
                        pick_coord(t_coord_mode'($urandom_range(2))),
                        $urandom_range(99) < 30, $urandom_range(99) < 12);
        end
    endtask

    task automatic test_extreme_square();
        send_vertex(16'sh8000, 16'sh8000, 1'b0, 1'b0);
        send_vertex(16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
        send_vertex(16'sh8000, 16'sh7FFF, 1'b1, 1'b1);
    endtask

    // The hole ends the region without its own contour flag.
    task automatic test_hole_subtraction();
        send_vertex(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_vertex(16'sd10, 16'sd0, 1'b0, 1'b0);
        send_vertex(16'sd10, 16'sd10, 1'b0, 1'b0);
        send_vertex(16'sd0, 16'sd10, 1'b1, 1'b0);
        send_vertex(16'sd1, 16'sd1, 1'b0, 1'b0);
        send_vertex(16'sd5, 16'sd1, 1'b0, 1'b0);
        send_vertex(16'sd1, 16'sd5, 1'b0, 1'b1);
    endtask

    task automatic test_single_vertex_contours();
        send_vertex(16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
        send_vertex(-16'sd1, -16'sd1, 1'b0, 1'b0);
        send_vertex(16'sd2, -16'sd1, 1'b0, 1'b0);
        send_vertex(16'sd2, 16'sd3, 1'b1, 1'b0);
        send_vertex(16'sd7, 16'sd7, 1'b1, 1'b1);
    endtask

    task automatic test_zero_length_edges();
        send_vertex(16'sd5, 16'sd5, 1'b0, 1'b0);
        send_vertex(16'sd5, 16'sd5, 1'b0, 1'b0);
        send_vertex(16'sd9, 16'sd5, 1'b0, 1'b0);
        send_vertex(16'sd9, 16'sd5, 1'b0, 1'b0);
        send_vertex(16'sd9, -16'sd3, 1'b1, 1'b1);
    endtask

    // A tiny outline minus a full-range hole gives a negative area.
    task automatic test_negative_area();
        send_vertex(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_vertex(16'sd1, 16'sd0, 1'b0, 1'b0);
        send_vertex(16'sd0, 16'sd1, 1'b1, 1'b0);
        send_vertex(16'sh8000, 16'sh8000, 1'b0, 1'b0);
        send_vertex(16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
        send_vertex(16'sh8000, 16'sh7FFF, 1'b1, 1'b1);
    endtask

    // Winding the full square many times drives the held outline area and
    // the perimeter into saturation; two holes of a few laps each, wound the
    // other way, push the net area below its lower limit.
    task automatic test_saturation();
        prm_pkg::t_coord sq_x[4];
        prm_pkg::t_coord sq_y[4];
        bit              last;
        sq_x = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
        sq_y = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF};
        for (int lap = 0; lap < SAT_LAPS; lap++) begin
            for (int k = 0; k < 4; k++) begin
                send_vertex(sq_x[k], sq_y[k], lap == SAT_LAPS - 1 && k == 3, 1'b0);
            end
        end
        for (int h = 0; h < 2; h++) begin
            for (int lap = 0; lap < HOLE_LAPS; lap++) begin
                for (int k = 0; k < 4; k++) begin
                    last = (lap == HOLE_LAPS - 1 && k == 3);
                    send_vertex(sq_x[3 - k], sq_y[3 - k], last, last && h == 1);
                end
            end
        end
    endtask

    task automatic test_random_regions(input int unsigned quota);
        int unsigned first_item;
        first_item = items_sent;
        while (items_sent - first_item < quota) begin
            if ($urandom_range(99) < 15) begin
                send_noise();
            end else begin
                send_region();
            end
        end
    endtask

    // The receiver holds off while triangles keep coming, so the core fills
    // up and has to stall its input.
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        -> stall_kick;
        for (int r = 0; r < 60; r++) begin
            send_contour(3, 1'b1, COORD_NEAR, 1'b0);
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        vertex_ch.valid       = 1'b0;
        vertex_ch.vertex_x    = '0;
        vertex_ch.vertex_y    = '0;
        vertex_ch.contour_end = 1'b0;
        vertex_ch.region_end  = 1'b0;
        send_idle_pct         = 12;
        recv_idle_pct         = 53;
        items_sent            = 0;
        results_checked       = 0;
        mismatch_count        = 0;
        cycle_count           = 0;
        clear_region();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_square();
        test_hole_subtraction();
        test_single_vertex_contours();
        test_zero_length_edges();
        test_negative_area();
        test_saturation();
        test_random_regions(210);
        send_idle_pct = 53;
        recv_idle_pct = 12;
        test_random_regions(210);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_regions(210);
        test_result_backpressure();

        vertex_ch.valid <= 1'b0;
        while (region_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && region_expect_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
